@@ rtl/elrc_pkg.sv @@
// ----------------------------------------------------------------------------
// elrc_pkg
// Shared types and constants for the event log ring with browse cursor.
// ----------------------------------------------------------------------------
package elrc_pkg;

  localparam int unsigned MaxSlotW    = 10;
  localparam int unsigned EntryCountW = 6;
  localparam logic [31:0] FirstSerial = 32'd101;

  typedef enum logic [1:0] {
    ReqAdd   = 2'd0,
    ReqNewer = 2'd1,
    ReqOlder = 2'd2,
    ReqClear = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    NavOk    = 2'd0,
    NavEnd   = 2'd1,
    NavStart = 2'd2
  } nav_status_e;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [1:0]         event_kind;
    logic signed [15:0] event_value;
    logic [31:0]        event_time;
  } req_t;

  typedef struct packed {
    logic               view_valid;
    logic [31:0]        view_id;
    logic [1:0]         view_kind;
    logic signed [15:0] view_value;
    logic [31:0]        view_time;
    logic [5:0]         entry_count;
    logic [1:0]         nav_status;
    logic               cursor_bumped;
    logic               live_echo;
    logic [31:0]        added_id;
  } result_t;

  typedef struct packed {
    logic [31:0]        id;
    logic [1:0]         kind;
    logic signed [15:0] value;
    logic [31:0]        stamp;
  } rec_t;

  typedef struct packed {
    logic                   view_valid;
    logic [EntryCountW-1:0] entry_count;
    logic [1:0]             nav_status;
    logic                   cursor_bumped;
    logic                   live_echo;
    logic [31:0]            added_id;
  } view_meta_t;

  typedef struct packed {
    logic                we;
    logic [MaxSlotW-1:0] wslot;
    rec_t                rec;
    logic [MaxSlotW-1:0] rslot;
    view_meta_t          meta;
  } cmd_t;

endpackage

@@ rtl/elrc_front.sv @@
// ----------------------------------------------------------------------------
// elrc_front
// Request decode and ring bookkeeping: pointers, count, cursor, serials.
// ----------------------------------------------------------------------------
module elrc_front import elrc_pkg::*; #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  req_t req_i,
  output logic full_o,
  input  logic cfg_we_i,
  input  logic cfg_data_i,
  output logic cmd_push_o,
  output cmd_t cmd_o,
  input  logic cmd_full_i
);

  localparam int unsigned SlotW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);
  localparam int unsigned SumW  = CntW + 1;
  localparam logic [SlotW-1:0] LastSlot = SlotW'(CAPACITY - 1);
  localparam logic [CntW-1:0]  CapCnt   = CntW'(CAPACITY);
  localparam logic [SumW-1:0]  CapSum   = SumW'(CAPACITY);

  logic [SlotW-1:0] oldest_q, oldest_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [SlotW-1:0] cursor_q, cursor_d;
  logic             cur_valid_q, cur_valid_d;
  logic [31:0]      serial_q, serial_d;
  logic             live_q;

  logic             accept;
  logic [CntW-1:0]  pos;
  logic [CntW-1:0]  cnt_tmp;
  logic [SlotW-1:0] old_tmp;
  logic [SumW-1:0]  sum;
  logic [SlotW-1:0] wslot;

  function automatic logic [SlotW-1:0] ring_next(logic [SlotW-1:0] s);
    return (s == LastSlot) ? '0 : s + SlotW'(1);
  endfunction

  function automatic logic [SlotW-1:0] ring_prev(logic [SlotW-1:0] s);
    return (s == '0) ? LastSlot : s - SlotW'(1);
  endfunction

  assign accept     = push_i && !cmd_full_i;
  assign full_o     = cmd_full_i;
  assign cmd_push_o = accept;
  assign pos        = (cursor_q >= oldest_q) ? CntW'(cursor_q) - CntW'(oldest_q)
                                             : CntW'(cursor_q) + CapCnt - CntW'(oldest_q);

  always_comb begin
    oldest_d    = oldest_q;
    count_d     = count_q;
    cursor_d    = cursor_q;
    cur_valid_d = cur_valid_q;
    serial_d    = serial_q;
    cnt_tmp     = count_q;
    old_tmp     = oldest_q;
    sum         = '0;
    wslot       = '0;
    cmd_o       = '0;

    unique case (req_type_e'(req_i.req_type))
      ReqAdd: begin
        if (count_q == CapCnt) begin
          if (cur_valid_q && cursor_q == oldest_q) begin
            if (count_q > CntW'(1)) begin
              cursor_d = ring_next(oldest_q);
            end else begin
              cur_valid_d = 1'b0;
            end
            cmd_o.meta.cursor_bumped = 1'b1;
          end
          old_tmp = ring_next(oldest_q);
          cnt_tmp = count_q - CntW'(1);
        end
        sum = SumW'(old_tmp) + SumW'(cnt_tmp);
        if (sum >= CapSum) begin
          sum = sum - CapSum;
        end
        wslot = sum[SlotW-1:0];
        if (cnt_tmp == '0) begin
          cursor_d    = wslot;
          cur_valid_d = 1'b1;
        end
        oldest_d               = old_tmp;
        count_d                = cnt_tmp + CntW'(1);
        serial_d               = serial_q + 32'd1;
        cmd_o.we               = 1'b1;
        cmd_o.wslot            = MaxSlotW'(wslot);
        cmd_o.rec.id           = serial_q;
        cmd_o.rec.kind         = req_i.event_kind;
        cmd_o.rec.value        = req_i.event_value;
        cmd_o.rec.stamp        = req_i.event_time;
        cmd_o.meta.added_id    = serial_q;
        cmd_o.meta.live_echo   = live_q;
        cmd_o.meta.nav_status  = NavOk;
      end
      ReqNewer: begin
        if (cur_valid_q && count_q != '0 && (pos + CntW'(1)) < count_q) begin
          cursor_d = ring_next(cursor_q);
          cmd_o.meta.nav_status = NavOk;
        end else begin
          cmd_o.meta.nav_status = NavEnd;
        end
      end
      ReqOlder: begin
        if (cur_valid_q && count_q != '0 && cursor_q != oldest_q) begin
          cursor_d = ring_prev(cursor_q);
          cmd_o.meta.nav_status = NavOk;
        end else begin
          cmd_o.meta.nav_status = NavStart;
        end
      end
      ReqClear: begin
        count_d               = '0;
        oldest_d              = '0;
        cursor_d              = '0;
        cur_valid_d           = 1'b0;
        cmd_o.meta.nav_status = NavOk;
      end
      default: begin
        cmd_o.meta.nav_status = NavOk;
      end
    endcase

    cmd_o.rslot            = MaxSlotW'(cursor_d);
    cmd_o.meta.view_valid  = cur_valid_d;
    cmd_o.meta.entry_count = EntryCountW'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q    <= '0;
      count_q     <= '0;
      cursor_q    <= '0;
      cur_valid_q <= 1'b0;
      serial_q    <= FirstSerial;
    end else if (accept) begin
      oldest_q    <= oldest_d;
      count_q     <= count_d;
      cursor_q    <= cursor_d;
      cur_valid_q <= cur_valid_d;
      serial_q    <= serial_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= 1'b0;
    end else if (cfg_we_i) begin
      live_q <= cfg_data_i;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapCnt)
    else $error("ring count exceeds capacity");

  a_cursor_iff_entries: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q == (count_q != '0))
    else $error("cursor validity disagrees with ring count");

  a_cursor_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q |-> (pos < count_q))
    else $error("cursor outside stored records");

  a_serial_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_type_e'(req_i.req_type) == ReqAdd) |=> serial_q == $past(serial_q) + 32'd1)
    else $error("serial did not advance on add");
`endif

endmodule

@@ rtl/elrc_fifo.sv @@
// ----------------------------------------------------------------------------
// elrc_fifo
// Two-entry command queue between the bookkeeping front and the storage back.
// ----------------------------------------------------------------------------
module elrc_fifo import elrc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t data_o
);

  logic [1:0] count_q, count_d;
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  cmd_t       slot_q [2];
  logic       do_push;
  logic       do_pop;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    count_d = count_q;
    unique case ({do_push, do_pop})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ rtl/elrc_back.sv @@
// ----------------------------------------------------------------------------
// elrc_back
// Record storage: write the added record, read the cursor record into the
// output word register.
// ----------------------------------------------------------------------------
module elrc_back import elrc_pkg::*; #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    cmd_valid_i,
  input  cmd_t    cmd_i,
  output logic    cmd_pop_o,
  output logic    empty_o,
  input  logic    pop_i,
  output result_t result_o
);

  localparam int unsigned SlotW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  rec_t       mem_q [CAPACITY];
  rec_t       rd_q;
  view_meta_t meta_q;
  logic       out_valid_q;
  logic       take;
  logic [SlotW-1:0] wslot;
  logic [SlotW-1:0] rslot;

  assign take      = cmd_valid_i && (!out_valid_q || pop_i);
  assign cmd_pop_o = take;
  assign empty_o   = !out_valid_q;
  assign wslot     = cmd_i.wslot[SlotW-1:0];
  assign rslot     = cmd_i.rslot[SlotW-1:0];

  always_ff @(posedge clk_i) begin
    if (take && cmd_i.we) begin
      mem_q[wslot] <= cmd_i.rec;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      meta_q <= cmd_i.meta;
      if (cmd_i.we && wslot == rslot) begin
        rd_q <= cmd_i.rec;
      end else begin
        rd_q <= mem_q[rslot];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_comb begin
    result_o               = '0;
    result_o.view_valid    = meta_q.view_valid;
    result_o.entry_count   = meta_q.entry_count;
    result_o.nav_status    = meta_q.nav_status;
    result_o.cursor_bumped = meta_q.cursor_bumped;
    result_o.live_echo     = meta_q.live_echo;
    result_o.added_id      = meta_q.added_id;
    if (meta_q.view_valid) begin
      result_o.view_id    = rd_q.id;
      result_o.view_kind  = rd_q.kind;
      result_o.view_value = rd_q.value;
      result_o.view_time  = rd_q.stamp;
    end
  end

endmodule

@@ rtl/event_log_ring_with_cursor.sv @@
// ----------------------------------------------------------------------------
// event_log_ring_with_cursor
// Bounded event log in a ring of CAPACITY records with a browse cursor.
//
// Channel   Handshake               Word
// request   push / full             req_i    (req_t)
// result    empty / pop             result_o (result_t)
// config    cfg_we_i                cfg_data_i (live display)
//
// One request is taken per cycle while full is low; its command is written into
// the command queue by the front bookkeeping, then the storage read registers
// its result word into the output register. The record store has one write and
// one read port per cycle. Reset zeroes pointers, count and cursor, and sets the
// serial to FirstSerial; records need no clearing.
// full rises when the two-word command queue fills behind a stalled output.
// ----------------------------------------------------------------------------
module event_log_ring_with_cursor import elrc_pkg::*; #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push,
  output logic    full,
  input  req_t    req_i,
  output logic    empty,
  input  logic    pop,
  output result_t result_o,
  input  logic    cfg_we_i,
  input  logic    cfg_data_i
);

  logic cmd_push;
  cmd_t cmd_in;
  logic cmd_full;
  logic cmd_valid;
  cmd_t cmd_out;
  logic cmd_pop;

  elrc_front #(
    .CAPACITY(CAPACITY)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .req_i      (req_i),
    .full_o     (full),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in),
    .cmd_full_i (cmd_full)
  );

  elrc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .data_o  (cmd_out)
  );

  elrc_back #(
    .CAPACITY(CAPACITY)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .result_o    (result_o)
  );

endmodule
